[rtl/pisc_pkg.sv]
// ----------------------------------------------------------------------------
// Panel interlock switch controller package
// Shared types, codes and reset values for the switch controller.
// ----------------------------------------------------------------------------
package pisc_pkg;

   // Opcodes of an input beat.
   localparam logic OP_SWITCH = 1'b0;
   localparam logic OP_POLL   = 1'b1;

   // Switch numbers with special roles.
   localparam logic [3:0] SW_TOGGLE = 4'd3;
   localparam logic [3:0] SW_LIGHT  = 4'd6;
   localparam logic [3:0] SW_MIRROR = 4'd7;
   localparam logic [3:0] SW_FIRE   = 4'd8;
   localparam logic [3:0] SW_LAST   = 4'd9;
   localparam logic [3:0] SW_KEY    = 4'd10;

   // Key actions.
   localparam logic [1:0] KEY_NONE    = 2'd0;
   localparam logic [1:0] KEY_TAP     = 2'd1;
   localparam logic [1:0] KEY_HOLD    = 2'd2;
   localparam logic [1:0] KEY_RELEASE = 2'd3;

   // Function key numbering: switch n maps to F13 + n.
   localparam logic [4:0] KEY_BASE   = 5'd13;
   localparam logic [4:0] KEY_TOGGLE = 5'd16;
   localparam logic [4:0] KEY_FIRE   = 5'd21;

   // Worklight modes.
   localparam logic [1:0] WL_OFF   = 2'd0;
   localparam logic [1:0] WL_WHITE = 2'd1;
   localparam logic [1:0] WL_RED   = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_INTERVAL   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_STEP       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_FLOOR      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_LEVEL     = 3'd4;
   localparam int unsigned CSR_DATA_W = 16;

   // Configuration reset values.
   localparam logic [15:0] RST_HOLD_THRESHOLD = 16'd500;
   localparam logic [15:0] RST_DIM_INTERVAL   = 16'd50;
   localparam logic [7:0]  RST_DIM_STEP       = 8'd5;
   localparam logic [7:0]  RST_DIM_FLOOR      = 8'd10;
   localparam logic [7:0]  RST_FULL_LEVEL     = 8'd255;
   localparam logic [7:0]  RST_LIGHT_LEVEL    = 8'd255;

   typedef struct packed {
      logic [15:0] hold_threshold_ms;
      logic [15:0] dim_interval_ms;
      logic [7:0]  dim_step;
      logic [7:0]  dim_floor;
      logic [7:0]  full_level;
   } cfg_type;

   typedef struct packed {
      logic        opcode;
      logic [3:0]  switch_id;
      logic        level;
      logic [31:0] now_ms;
      logic        all_low;
   } req_type;

   typedef struct packed {
      logic        locked;
      logic        confirmed;
      logic        arm_one;
      logic        toggle_three;
      logic [1:0]  light_mode;
      logic [7:0]  light_level;
      logic [31:0] press_start;
      logic        held_flag;
      logic [31:0] last_dim_time;
   } state_type;

   typedef struct packed {
      logic [1:0] key_action;
      logic [4:0] key_number;
      logic       led_write;
      logic [3:0] led_index;
      logic       led_on;
      logic       led_mirror_write;
      logic       worklight_write;
      logic [1:0] worklight_mode;
      logic [7:0] worklight_level;
      logic       failsafe;
      logic       locked_out;
      logic       confirmed_out;
   } rsp_type;

endpackage

[rtl/pisc_core.sv]
// ----------------------------------------------------------------------------
// Panel interlock switch controller step logic
// Computes the next panel state and the result beat for one input beat.
// ----------------------------------------------------------------------------
module pisc_core
   import pisc_pkg::*;
(
   input  req_type   req,
   input  state_type cur,
   input  cfg_type   cfg,
   output state_type nxt,
   output rsp_type   rsp
);

   logic        enabled;
   logic [31:0] press_base;
   logic [31:0] press_dur;
   logic [31:0] since_dim;
   logic [31:0] hold_thr;
   logic        past_hold;
   logic        short_press;
   logic        dim_due;
   logic [7:0]  dimmed_level;
   logic [1:0]  cycled_mode;
   logic [7:0]  cycled_level;

   always_comb begin
      enabled    = !cur.locked && cur.confirmed;
      // A new press starts now, so its duration is zero on the first beat.
      press_base = cur.held_flag ? cur.press_start : req.now_ms;
      press_dur  = req.now_ms - press_base;
      since_dim  = req.now_ms - cur.last_dim_time;
      hold_thr   = {16'd0, cfg.hold_threshold_ms};
      past_hold  = press_dur > hold_thr;
      short_press = press_dur < hold_thr;
      dim_due    = since_dim > {16'd0, cfg.dim_interval_ms};

      if (cur.light_level > cfg.dim_floor) begin
         dimmed_level = (cur.light_level > cfg.dim_step) ?
                        cur.light_level - cfg.dim_step : 8'd0;
      end else begin
         dimmed_level = cfg.full_level;
      end

      unique case (cur.light_mode)
         WL_OFF: begin
            cycled_mode  = WL_WHITE;
            cycled_level = cfg.full_level;
         end
         WL_WHITE: begin
            cycled_mode  = WL_RED;
            cycled_level = cfg.full_level;
         end
         WL_RED: begin
            cycled_mode  = WL_OFF;
            cycled_level = cfg.full_level;
         end
         default: begin
            cycled_mode  = cur.light_mode;
            cycled_level = cur.light_level;
         end
      endcase
   end

   always_comb begin
      nxt = cur;
      rsp = '0;

      if (req.opcode == OP_POLL) begin
         if (req.all_low) begin
            nxt.confirmed = 1'b1;
         end
      end else if (req.switch_id == SW_KEY) begin
         if (req.level) begin
            nxt.locked    = 1'b0;
            nxt.confirmed = req.all_low;
         end else begin
            // Locking turns the light off but keeps its brightness.
            nxt.locked          = 1'b1;
            nxt.confirmed       = 1'b0;
            nxt.light_mode      = WL_OFF;
            rsp.worklight_write = 1'b1;
         end
      end else if (req.switch_id <= SW_LAST) begin
         if (req.switch_id == SW_TOGGLE) begin
            if (req.level && enabled) begin
               nxt.toggle_three = !cur.toggle_three;
               rsp.key_action   = nxt.toggle_three ? KEY_HOLD : KEY_RELEASE;
               rsp.key_number   = KEY_TOGGLE;
            end
            if (!cur.locked) begin
               rsp.led_write = 1'b1;
               rsp.led_index = SW_TOGGLE;
               rsp.led_on    = nxt.toggle_three;
            end
         end else if (req.switch_id == SW_FIRE) begin
            if (req.level && enabled) begin
               if (cur.arm_one) begin
                  rsp.key_action = KEY_TAP;
                  rsp.key_number = KEY_FIRE;
                  rsp.led_write  = 1'b1;
                  rsp.led_index  = SW_FIRE;
                  rsp.led_on     = 1'b1;
               end else begin
                  rsp.failsafe = 1'b1;
               end
            end
         end else begin
            if (req.switch_id == SW_LIGHT) begin
               if (req.level) begin
                  if (!cur.held_flag) begin
                     nxt.press_start = req.now_ms;
                     nxt.held_flag   = 1'b1;
                  end
                  if (past_hold && cur.light_mode != WL_OFF && dim_due) begin
                     nxt.last_dim_time   = req.now_ms;
                     nxt.light_level     = dimmed_level;
                     rsp.worklight_write = 1'b1;
                  end
                  nxt.arm_one = 1'b1;
               end else begin
                  if (cur.held_flag) begin
                     if (short_press) begin
                        nxt.light_mode      = cycled_mode;
                        nxt.light_level     = cycled_level;
                        rsp.worklight_write = 1'b1;
                     end
                     nxt.held_flag = 1'b0;
                  end
                  nxt.arm_one = 1'b0;
               end
            end
            if (req.level && enabled) begin
               rsp.key_action = KEY_TAP;
               rsp.key_number = KEY_BASE + {1'b0, req.switch_id};
            end
            if (!cur.locked) begin
               rsp.led_write = 1'b1;
               rsp.led_index = req.switch_id;
               rsp.led_on    = req.level;
               rsp.led_mirror_write = (req.switch_id == SW_LIGHT) ||
                                      (req.switch_id == SW_MIRROR);
            end
         end
      end

      rsp.worklight_mode  = nxt.light_mode;
      rsp.worklight_level = nxt.light_level;
      rsp.locked_out      = nxt.locked;
      rsp.confirmed_out   = nxt.confirmed;
   end

endmodule

[rtl/panel_interlock_switch_controller.sv]
// ----------------------------------------------------------------------------
// Panel interlock switch controller
// Lock, confirmation, arming, toggle and worklight control for a switch panel.
//
//   Channel  Direction  Handshake          Content
//   req_     in         valid / stall      switch event or poll
//   rsp_     out        valid / stall      key, indicator and worklight result
//   csr_     in         valid / ready      register index and write data
//
// One result beat per request beat; a beat passes through the input register,
// then the result register, and a new beat is taken every cycle unless
// stalled. The panel state updates as a beat moves into the result register.
// A stalled result holds; the input register keeps taking a beat while the
// result register is free or being emptied. Reset leaves the panel locked and
// the registers at their defaults; csr_ready is always high.
// ----------------------------------------------------------------------------
module panel_interlock_switch_controller
   import pisc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [3:0]            req_switch_id,
   input  logic                  req_level,
   input  logic [31:0]           req_now_ms,
   input  logic                  req_all_low,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_key_action,
   output logic [4:0]            rsp_key_number,
   output logic                  rsp_led_write,
   output logic [3:0]            rsp_led_index,
   output logic                  rsp_led_on,
   output logic                  rsp_led_mirror_write,
   output logic                  rsp_worklight_write,
   output logic [1:0]            rsp_worklight_mode,
   output logic [7:0]            rsp_worklight_level,
   output logic                  rsp_failsafe,
   output logic                  rsp_locked_out,
   output logic                  rsp_confirmed_out,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   req_type   req_ff;
   logic      req_valid_ff;
   state_type state_ff;
   state_type state_in;
   cfg_type   cfg_ff;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;
   logic      rsp_free;
   logic      advance;
   logic      req_take;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && rsp_free;
   assign req_stall = req_valid_ff && !rsp_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   pisc_core u_core (
      .req (req_ff),
      .cur (state_ff),
      .cfg (cfg_ff),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_take) begin
         req_valid_ff <= 1'b1;
      end else if (advance) begin
         req_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.opcode    <= req_opcode;
         req_ff.switch_id <= req_switch_id;
         req_ff.level     <= req_level;
         req_ff.now_ms    <= req_now_ms;
         req_ff.all_low   <= req_all_low;
      end
   end

   // Panel state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.locked        <= 1'b1;
         state_ff.confirmed     <= 1'b1;
         state_ff.arm_one       <= 1'b0;
         state_ff.toggle_three  <= 1'b0;
         state_ff.light_mode    <= WL_OFF;
         state_ff.light_level   <= RST_LIGHT_LEVEL;
         state_ff.press_start   <= 32'd0;
         state_ff.held_flag     <= 1'b0;
         state_ff.last_dim_time <= 32'd0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_threshold_ms <= RST_HOLD_THRESHOLD;
         cfg_ff.dim_interval_ms   <= RST_DIM_INTERVAL;
         cfg_ff.dim_step          <= RST_DIM_STEP;
         cfg_ff.dim_floor         <= RST_DIM_FLOOR;
         cfg_ff.full_level        <= RST_FULL_LEVEL;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HOLD_THRESHOLD: cfg_ff.hold_threshold_ms <= csr_wdata;
            CSR_DIM_INTERVAL:   cfg_ff.dim_interval_ms   <= csr_wdata;
            CSR_DIM_STEP:       cfg_ff.dim_step          <= csr_wdata[7:0];
            CSR_DIM_FLOOR:      cfg_ff.dim_floor         <= csr_wdata[7:0];
            CSR_FULL_LEVEL:     cfg_ff.full_level        <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_key_action       = rsp_ff.key_action;
   assign rsp_key_number       = rsp_ff.key_number;
   assign rsp_led_write        = rsp_ff.led_write;
   assign rsp_led_index        = rsp_ff.led_index;
   assign rsp_led_on           = rsp_ff.led_on;
   assign rsp_led_mirror_write = rsp_ff.led_mirror_write;
   assign rsp_worklight_write  = rsp_ff.worklight_write;
   assign rsp_worklight_mode   = rsp_ff.worklight_mode;
   assign rsp_worklight_level  = rsp_ff.worklight_level;
   assign rsp_failsafe         = rsp_ff.failsafe;
   assign rsp_locked_out       = rsp_ff.locked_out;
   assign rsp_confirmed_out    = rsp_ff.confirmed_out;

   // A beat leaving the input register always lands in the result register.
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("beat left the input register without a result");

   // The input side only stalls while both stages hold a beat.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (req_valid_ff && rsp_valid_ff))
      else $error("input stalled with a free stage");

   // A locked panel never emits a key.
   a_locked_no_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.locked_out) |-> (rsp_ff.key_action == KEY_NONE))
      else $error("key emitted while locked");

   // Failsafe excludes the fire key and its indicator.
   a_failsafe_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.failsafe) |->
         (rsp_ff.key_action == KEY_NONE && !rsp_ff.led_write))
      else $error("failsafe together with a key or indicator");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Panel interlock switch controller testbench
// Drives switch and poll beats through the request channel, predicts each
// result beat from a private copy of the panel state and register settings,
// and compares every field of every result in order. Directed cases come
// first, then random switch sequences under several register settings with
// random idling on both channels and a long output hold.
// ----------------------------------------------------------------------------
module tb;
   import pisc_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 6;
   localparam int TAIL_CYCLES   = 10;
   localparam int REPORT_MAX    = 200;
   localparam logic [31:0] WRAP_START = 32'hFFFF_F800;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_opcode;
   logic [3:0]            req_switch_id;
   logic                  req_level;
   logic [31:0]           req_now_ms;
   logic                  req_all_low;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_key_action;
   logic [4:0]            rsp_key_number;
   logic                  rsp_led_write;
   logic [3:0]            rsp_led_index;
   logic                  rsp_led_on;
   logic                  rsp_led_mirror_write;
   logic                  rsp_worklight_write;
   logic [1:0]            rsp_worklight_mode;
   logic [7:0]            rsp_worklight_level;
   logic                  rsp_failsafe;
   logic                  rsp_locked_out;
   logic                  rsp_confirmed_out;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   panel_interlock_switch_controller dut (.*);

   // Private copy of the panel state and register settings.
   cfg_type     cfg;
   logic        pnl_locked;
   logic        pnl_confirmed;
   logic        pnl_armed;
   logic        pnl_toggle;
   logic [1:0]  pnl_mode;
   logic [7:0]  pnl_level;
   logic [31:0] pnl_press_t;
   logic        pnl_held;
   logic [31:0] pnl_dim_t;

   rsp_type     panel_results_due[$];
   logic [31:0] now_t;
   int          idle_pct;
   int          stall_pct;
   int          hold_ticket;
   int          hold_seen;
   int          hold_left;
   int          beats_sent;
   int          results_checked;
   int          settings_written;
   int          error_count;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: done, errors");
      $finish;
   end

   task automatic reset_panel_copy();
      cfg.hold_threshold_ms = RST_HOLD_THRESHOLD;
      cfg.dim_interval_ms   = RST_DIM_INTERVAL;
      cfg.dim_step          = RST_DIM_STEP;
      cfg.dim_floor         = RST_DIM_FLOOR;
      cfg.full_level        = RST_FULL_LEVEL;
      pnl_locked    = 1'b1;
      pnl_confirmed = 1'b1;
      pnl_armed     = 1'b0;
      pnl_toggle    = 1'b0;
      pnl_mode      = WL_OFF;
      pnl_level     = RST_LIGHT_LEVEL;
      pnl_press_t   = '0;
      pnl_held      = 1'b0;
      pnl_dim_t     = '0;
   endtask

   // Switch 6: start a press, dim while held past the threshold, or cycle the
   // mode on a short release. Returns whether the worklight is written.
   function automatic logic light_switch_step(input logic pressed, input logic [31:0] t);
      logic        wrote;
      logic [31:0] held_for;
      logic [31:0] since_dim;
      wrote = 1'b0;
      if (pressed) begin
         if (!pnl_held) begin
            pnl_press_t = t;
            pnl_held    = 1'b1;
         end
         held_for  = t - pnl_press_t;
         since_dim = t - pnl_dim_t;
         if (held_for > {16'd0, cfg.hold_threshold_ms} && pnl_mode != WL_OFF) begin
            if (since_dim > {16'd0, cfg.dim_interval_ms}) begin
               pnl_dim_t = t;
               if (pnl_level > cfg.dim_floor)
                  pnl_level = (pnl_level > cfg.dim_step) ? pnl_level - cfg.dim_step : 8'd0;
               else
                  pnl_level = cfg.full_level;
               wrote = 1'b1;
            end
         end
         pnl_armed = 1'b1;
      end else begin
         if (pnl_held) begin
            held_for = t - pnl_press_t;
            if (held_for < {16'd0, cfg.hold_threshold_ms}) begin
               case (pnl_mode)
                  WL_OFF: begin
                     pnl_mode  = WL_WHITE;
                     pnl_level = cfg.full_level;
                  end
                  WL_WHITE: begin
                     pnl_mode  = WL_RED;
                     pnl_level = cfg.full_level;
                  end
                  WL_RED: begin
                     pnl_mode  = WL_OFF;
                     pnl_level = cfg.full_level;
                  end
                  default: ;
               endcase
               wrote = 1'b1;
            end
            pnl_held = 1'b0;
         end
         pnl_armed = 1'b0;
      end
      return wrote;
   endfunction

   function automatic rsp_type predict_panel_result(input req_type r);
      rsp_type o;
      logic    enabled;
      o = '0;
      enabled = !pnl_locked && pnl_confirmed;
      if (r.opcode == OP_POLL) begin
         if (r.all_low) pnl_confirmed = 1'b1;
      end else if (r.switch_id == SW_KEY) begin
         if (r.level) begin
            pnl_locked    = 1'b0;
            pnl_confirmed = r.all_low;
         end else begin
            pnl_locked        = 1'b1;
            pnl_confirmed     = 1'b0;
            pnl_mode          = WL_OFF;
            o.worklight_write = 1'b1;
         end
      end else if (r.switch_id <= SW_LAST) begin
         if (r.switch_id == SW_TOGGLE) begin
            if (r.level && enabled) begin
               pnl_toggle   = !pnl_toggle;
               o.key_action = pnl_toggle ? KEY_HOLD : KEY_RELEASE;
               o.key_number = KEY_TOGGLE;
            end
            if (!pnl_locked) begin
               o.led_write = 1'b1;
               o.led_index = SW_TOGGLE;
               o.led_on    = pnl_toggle;
            end
         end else if (r.switch_id == SW_FIRE) begin
            if (r.level && enabled) begin
               if (pnl_armed) begin
                  o.key_action = KEY_TAP;
                  o.key_number = KEY_FIRE;
                  o.led_write  = 1'b1;
                  o.led_index  = SW_FIRE;
                  o.led_on     = 1'b1;
               end else begin
                  o.failsafe = 1'b1;
               end
            end
         end else begin
            if (r.switch_id == SW_LIGHT)
               o.worklight_write = light_switch_step(r.level, r.now_ms);
            if (r.level && enabled) begin
               o.key_action = KEY_TAP;
               o.key_number = KEY_BASE + {1'b0, r.switch_id};
            end
            if (!pnl_locked) begin
               o.led_write        = 1'b1;
               o.led_index        = r.switch_id;
               o.led_on           = r.level;
               o.led_mirror_write = (r.switch_id == SW_LIGHT) || (r.switch_id == SW_MIRROR);
            end
         end
      end
      o.worklight_mode  = pnl_mode;
      o.worklight_level = pnl_level;
      o.locked_out      = pnl_locked;
      o.confirmed_out   = pnl_confirmed;
      return o;
   endfunction

   function automatic req_type make_beat(input logic op, input logic [3:0] id,
                                         input logic lv, input logic [31:0] t,
                                         input logic al);
      req_type r;
      r.opcode    = op;
      r.switch_id = id;
      r.level     = lv;
      r.now_ms    = t;
      r.all_low   = al;
      return r;
   endfunction

   // Offers one beat and books its result once the beat is taken. Valid stays
   // high on return so that back-to-back beats need no second assignment.
   task automatic send_beat(input req_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= r.opcode;
      req_switch_id <= r.switch_id;
      req_level     <= r.level;
      req_now_ms    <= r.now_ms;
      req_all_low   <= r.all_low;
      do @(posedge clock); while (req_stall);
      panel_results_due.push_back(predict_panel_result(r));
      beats_sent++;
   endtask

   task automatic switch_beat(input logic [3:0] id, input logic lv);
      logic al;
      al = 1'($urandom_range(1));
      send_beat(make_beat(OP_SWITCH, id, lv, now_t, al));
   endtask

   task automatic key_beat(input logic lv, input logic al);
      send_beat(make_beat(OP_SWITCH, SW_KEY, lv, now_t, al));
   endtask

   task automatic poll_beat(input logic al);
      logic [3:0] id;
      logic       lv;
      id = 4'($urandom_range(15));
      lv = 1'($urandom_range(1));
      send_beat(make_beat(OP_POLL, id, lv, $urandom, al));
   endtask

   // Must be called at the step where the last beat was taken.
   task automatic quiesce();
      req_valid <= 1'b0;
      while (panel_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(input logic [15:0] thr, input logic [15:0] intv,
                                 input logic [15:0] stp, input logic [15:0] flr,
                                 input logic [15:0] full);
      logic [CSR_IDX_W-1:0] idx [5];
      logic [15:0]          val [5];
      idx[0] = CSR_HOLD_THRESHOLD; val[0] = thr;
      idx[1] = CSR_DIM_INTERVAL;   val[1] = intv;
      idx[2] = CSR_DIM_STEP;       val[2] = stp;
      idx[3] = CSR_DIM_FLOOR;      val[3] = flr;
      idx[4] = CSR_FULL_LEVEL;     val[4] = full;
      quiesce();
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         do @(posedge clock); while (!csr_ready);
         case (idx[i])
            CSR_HOLD_THRESHOLD: cfg.hold_threshold_ms = val[i];
            CSR_DIM_INTERVAL:   cfg.dim_interval_ms   = val[i];
            CSR_DIM_STEP:       cfg.dim_step          = val[i][7:0];
            CSR_DIM_FLOOR:      cfg.dim_floor         = val[i][7:0];
            CSR_FULL_LEVEL:     cfg.full_level        = val[i][7:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
      settings_written++;
   endtask

   // Gaps chosen to land near the dimming interval and the hold threshold.
   function automatic logic [31:0] light_gap();
      case ($urandom_range(3))
         0: return $urandom_range(0, 12);
         1: return {16'd0, cfg.dim_interval_ms} + $urandom_range(0, 2);
         2: return {16'd0, cfg.hold_threshold_ms} + $urandom_range(0, 2) - 1;
         default: return $urandom_range(0, cfg.hold_threshold_ms);
      endcase
   endfunction

   task automatic light_sequence();
      int holds;
      holds = $urandom_range(0, 6);
      switch_beat(SW_LIGHT, 1'b1);
      repeat (holds) begin
         now_t += light_gap();
         switch_beat(SW_LIGHT, 1'b1);
      end
      now_t += light_gap();
      switch_beat(SW_LIGHT, 1'b0);
   endtask

   task automatic fire_sequence();
      logic armed;
      armed = 1'($urandom_range(1));
      if (armed) switch_beat(SW_LIGHT, 1'b1);
      now_t += $urandom_range(0, 20);
      switch_beat(SW_FIRE, 1'b1);
      now_t += $urandom_range(0, 20);
      switch_beat(SW_FIRE, 1'b0);
      now_t += $urandom_range(0, 20);
      if (armed) switch_beat(SW_LIGHT, 1'b0);
   endtask

   // Mostly well-formed switch sequences on an unlocked panel, with locking,
   // polls and fully random beats mixed in.
   task automatic random_traffic(input int count);
      int         first;
      int         pick;
      logic [3:0] id;
      logic       lv;
      logic       al;
      first = beats_sent;
      key_beat(1'b1, 1'b1);
      while (beats_sent - first < count) begin
         now_t += $urandom_range(0, 25);
         pick = $urandom_range(99);
         if (pick < 8) begin
            id = 4'($urandom_range(15));
            lv = 1'($urandom_range(1));
            al = 1'($urandom_range(1));
            send_beat(make_beat(1'($urandom_range(1)), id, lv, $urandom, al));
         end else if (pick < 14) begin
            key_beat(1'b1, $urandom_range(3) != 0);
            if ($urandom_range(1)) poll_beat(1'b1);
         end else if (pick < 18) begin
            key_beat(1'b0, 1'($urandom_range(1)));
         end else if (pick < 22) begin
            poll_beat(1'($urandom_range(1)));
         end else if (pick < 42) begin
            light_sequence();
         end else if (pick < 54) begin
            fire_sequence();
         end else if (pick < 66) begin
            switch_beat(SW_TOGGLE, 1'b1);
            now_t += $urandom_range(0, 30);
            switch_beat(SW_TOGGLE, 1'b0);
         end else if (pick < 84) begin
            id = 4'($urandom_range(SW_LAST));
            switch_beat(id, 1'b1);
            now_t += $urandom_range(0, 30);
            switch_beat(id, 1'b0);
         end else begin
            id = 4'($urandom_range(SW_LAST));
            switch_beat(id, 1'($urandom_range(1)));
         end
      end
   endtask

   task automatic test_directed();
      idle_pct  = 0;
      stall_pct = 0;
      now_t     = 32'd1000;
      poll_beat(1'b1);                    // locked panel: nothing but flags
      switch_beat(4'd0, 1'b1);            // locked: no key, no indicator
      send_beat(make_beat(OP_SWITCH, 4'hF, 1'b1, 32'hFFFF_FFFF, 1'b1));
      key_beat(1'b1, 1'b0);               // unlocked but not confirmed
      switch_beat(4'd2, 1'b1);            // indicator only
      poll_beat(1'b0);
      poll_beat(1'b1);                    // confirms
      switch_beat(SW_LAST, 1'b1);
      switch_beat(4'd0, 1'b1);
      switch_beat(4'd0, 1'b0);
      switch_beat(SW_TOGGLE, 1'b1);
      switch_beat(SW_TOGGLE, 1'b0);
      switch_beat(SW_TOGGLE, 1'b1);
      switch_beat(SW_FIRE, 1'b1);         // not armed: failsafe
      now_t = 32'd1000;
      switch_beat(SW_LIGHT, 1'b1);
      switch_beat(SW_FIRE, 1'b1);         // armed by the held light switch
      switch_beat(SW_FIRE, 1'b0);
      now_t = 32'd1100;
      switch_beat(SW_LIGHT, 1'b0);        // short press: light turns white
      switch_beat(SW_MIRROR, 1'b1);
      now_t = 32'd2000;
      switch_beat(SW_LIGHT, 1'b1);
      now_t = 32'd2500;
      switch_beat(SW_LIGHT, 1'b1);        // held exactly the threshold
      now_t = 32'd2501;
      switch_beat(SW_LIGHT, 1'b1);        // first dimming step
      now_t = 32'd2540;
      switch_beat(SW_LIGHT, 1'b1);        // too soon for another step
      now_t = 32'd2552;
      switch_beat(SW_LIGHT, 1'b1);
      now_t = 32'd2600;
      switch_beat(SW_LIGHT, 1'b0);        // long press: no mode change
      key_beat(1'b0, 1'b1);               // locking turns the light off
   endtask

   task automatic test_low_extremes();
      write_settings(16'd0, 16'd0, 16'd255, 16'd0, 16'd0);
      idle_pct  = 58;
      stall_pct = 0;
      random_traffic(270);
   endtask

   task automatic test_high_extremes();
      write_settings(16'hFFFF, 16'hFFFF, 16'd1, 16'd255, 16'd255);
      idle_pct  = 0;
      stall_pct = 58;
      random_traffic(270);
   endtask

   // Random settings, with junk in the unused upper byte of the narrow
   // registers, and a time base that wraps during the phase.
   task automatic test_random_settings();
      logic [7:0] junk;
      junk = 8'($urandom);
      write_settings(16'($urandom_range(0, 600)), 16'($urandom_range(0, 80)),
                     {junk, 8'($urandom_range(1, 255))}, {~junk, 8'($urandom_range(0, 60))},
                     {junk, 8'($urandom_range(0, 255))});
      idle_pct  = 32;
      stall_pct = 32;
      now_t     = WRAP_START;
      random_traffic(270);
   endtask

   task automatic test_defaults_no_idle();
      write_settings(RST_HOLD_THRESHOLD, RST_DIM_INTERVAL, {8'd0, RST_DIM_STEP},
                     {8'd0, RST_DIM_FLOOR}, {8'd0, RST_FULL_LEVEL});
      idle_pct  = 0;
      stall_pct = 0;
      random_traffic(270);
   endtask

   // The output is held for a long stretch while beats keep coming, so the
   // block fills and pushes back; then the sender waits for the backlog.
   task automatic test_output_hold();
      idle_pct  = 0;
      stall_pct = 0;
      hold_ticket++;
      repeat (24) begin
         now_t += $urandom_range(0, 20);
         switch_beat(4'($urandom_range(SW_LAST)), 1'($urandom_range(1)));
      end
      quiesce();
      random_traffic(30);
   endtask

   always @(posedge clock) begin
      if (hold_seen != hold_ticket) begin
         hold_seen = hold_ticket;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         // Later mismatches are only counted, to keep the log short.
         if (error_count < REPORT_MAX)
            $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (panel_results_due.size() == 0) begin
            $error("result beat arrived with no result pending");
            error_count++;
         end else begin
            want = panel_results_due.pop_front();
            check_field("key_action", 32'(want.key_action), 32'(rsp_key_action));
            check_field("key_number", 32'(want.key_number), 32'(rsp_key_number));
            check_field("led_write", 32'(want.led_write), 32'(rsp_led_write));
            check_field("led_index", 32'(want.led_index), 32'(rsp_led_index));
            check_field("led_on", 32'(want.led_on), 32'(rsp_led_on));
            check_field("led_mirror_write", 32'(want.led_mirror_write),
                        32'(rsp_led_mirror_write));
            check_field("worklight_write", 32'(want.worklight_write),
                        32'(rsp_worklight_write));
            check_field("worklight_mode", 32'(want.worklight_mode),
                        32'(rsp_worklight_mode));
            check_field("worklight_level", 32'(want.worklight_level),
                        32'(rsp_worklight_level));
            check_field("failsafe", 32'(want.failsafe), 32'(rsp_failsafe));
            check_field("locked_out", 32'(want.locked_out), 32'(rsp_locked_out));
            check_field("confirmed_out", 32'(want.confirmed_out), 32'(rsp_confirmed_out));
            results_checked++;
         end
      end
   end

   initial begin
      hold_ticket      = 0;
      hold_seen        = 0;
      hold_left        = 0;
      beats_sent       = 0;
      results_checked  = 0;
      settings_written = 0;
      error_count      = 0;
      idle_pct         = 0;
      stall_pct        = 0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_opcode    <= OP_SWITCH;
      req_switch_id <= '0;
      req_level     <= 1'b0;
      req_now_ms    <= '0;
      req_all_low   <= 1'b0;
      csr_valid     <= 1'b0;
      csr_index     <= CSR_HOLD_THRESHOLD;
      csr_wdata     <= '0;
      reset_panel_copy();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_low_extremes();
      test_high_extremes();
      test_random_settings();
      test_defaults_no_idle();
      test_output_hold();

      quiesce();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("tb: %0d request beats sent, %0d result beats checked field by field",
               beats_sent, results_checked);
      $display("tb: directed cases, %0d register settings, idling on both sides, long hold",
               settings_written);
      if (error_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
